// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held low.
`define CTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define CTP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ctp_pkg.sv -----
// Types, constants and codes of the call tree profiler.
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

    localparam int POOL_ENTRIES = 2048;
    localparam int NODE_W       = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = NODE_W + 1;
    localparam int PC_BITS      = 32;
    localparam int CNT_W        = 32;
    localparam int TIME_W       = 64;
    localparam int PID_W        = 32;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(POOL_ENTRIES);

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_START = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_READ    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TM_KERNEL  = 2'd0,
        TM_USER    = 2'd1,
        TM_ELAPSED = 2'd2,
        TM_SAMPLE  = 2'd3
    } time_mode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_MODE  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_PID = CFG_INDEX_W'(1);

    typedef struct packed {
        time_mode_t       time_mode;
        logic [PID_W-1:0] filter_pid;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [PC_BITS-1:0] call_pc;
        logic [PID_W-1:0]   proc_id;
        logic [TIME_W-1:0]  cycle_count;
        logic [TIME_W-1:0]  kernel_cycles;
        logic [TIME_W-1:0]  proc_cycles;
        logic [TIME_W-1:0]  clock_ticks;
        logic [NODE_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [NODE_W-1:0]        node_index;
        logic [LINK_W-1:0]        first_child;
        logic [LINK_W-1:0]        next_sibling;
        logic [PC_BITS-1:0]       node_pc;
        logic [CNT_W-1:0]         node_count;
        logic signed [TIME_W-1:0] node_time;
        logic [CNT_W-1:0]         error_count;
    } out_item_t;

    // One node of the call tree as held in the record memory.
    typedef struct packed {
        logic [NODE_W-1:0]  parent;
        logic [LINK_W-1:0]  child;
        logic [LINK_W-1:0]  sibling;
        logic [PC_BITS-1:0] pc;
        logic [CNT_W-1:0]   count;
        logic [TIME_W-1:0]  ticks;
    } node_rec_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        node_rec_t         wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- hdl/ctp_node_ram.sv -----
// Node record memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module ctp_node_ram (
    input  wire logic              aclk,
    input  wire ctp_pkg::mem_req_t req,
    output ctp_pkg::node_rec_t     rd_data
);
    import ctp_pkg::*;

    node_rec_t node_mem [POOL_ENTRIES];
    node_rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            node_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= node_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/ctp_ctrl.sv -----
// Sequencer: walks child lists and read-modify-writes node records.
`timescale 1ns / 1ps
`default_nettype none

module ctp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ctp_pkg::cfg_t       cfg,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ctp_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ctp_pkg::out_item_t       m_data,
    output ctp_pkg::mem_req_t        mem_req,
    input  wire ctp_pkg::node_rec_t  mem_rd_data
);
    import ctp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_UPD_WR,
        S_EXIT_WR,
        S_RES_WAIT,
        S_ALLOC,
        S_LINK_WR,
        S_EMIT
    } state_t;

    state_t            state_reg;
    in_item_t          item_reg;
    node_rec_t         rec_reg;
    node_rec_t         res_rec_reg;
    status_t           status_reg;
    logic [NODE_W-1:0] idx_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] last_used_reg;
    logic [NODE_W-1:0] walk_reg;
    logic [LINK_W-1:0] head_reg;
    logic              active_reg;
    logic [CNT_W-1:0]  err_reg;
    logic [TIME_W-1:0] delta_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              accept;
    logic              pid_ok;
    logic              pc_hit;
    logic [LINK_W-1:0] new_link;
    logic              pool_full;
    logic [TIME_W-1:0] delta;
    node_rec_t         root_rec;
    node_rec_t         new_rec;
    node_rec_t         upd_rec;
    node_rec_t         exit_rec;
    node_rec_t         link_rec;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign pid_ok    = (cfg.filter_pid == '0) || (item_reg.proc_id == cfg.filter_pid);
    assign pc_hit    = (mem_rd_data.pc == item_reg.call_pc);
    assign new_link  = {1'b0, last_used_reg} + LINK_W'(1);
    assign pool_full = (new_link >= NO_LINK);

    // Stamp added to a node's time on enter and taken off on exit.
    always_comb begin
        case (cfg.time_mode)
            TM_KERNEL:  delta = '0 - item_reg.proc_cycles - item_reg.cycle_count;
            TM_USER:    delta = item_reg.kernel_cycles - item_reg.cycle_count;
            TM_ELAPSED: delta = '0 - item_reg.cycle_count;
            default:    delta = '0 - item_reg.clock_ticks;
        endcase
    end

    always_comb begin
        root_rec         = '0;
        root_rec.child   = NO_LINK;
        root_rec.sibling = NO_LINK;

        new_rec         = '0;
        new_rec.parent  = cur_reg;
        new_rec.child   = NO_LINK;
        new_rec.sibling = head_reg;
        new_rec.pc      = item_reg.call_pc;
        new_rec.count   = CNT_W'(1);
        new_rec.ticks   = delta_reg;

        upd_rec       = rec_reg;
        upd_rec.count = rec_reg.count + CNT_W'(1);
        upd_rec.ticks = rec_reg.ticks + delta_reg;

        exit_rec       = rec_reg;
        exit_rec.ticks = rec_reg.ticks - delta_reg;

        // Push the fresh node at the head of the old current node's list
        link_rec       = rec_reg;
        link_rec.child = {1'b0, idx_reg};
    end

    always_comb begin
        mem_req         = '0;
        mem_req.rd_addr = cur_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == OP_START) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = root_rec;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = (s_data.opcode == OP_READ) ?
                                          s_data.read_index : cur_reg;
                    end
                end
            end
            S_FETCH: begin
                mem_req.rd_addr = mem_rd_data.child[NODE_W-1:0];
                mem_req.rd_en   = (item_reg.opcode == OP_ENTER) && active_reg && pid_ok &&
                                  (mem_rd_data.child < NO_LINK);
            end
            S_WALK: begin
                mem_req.rd_addr = mem_rd_data.sibling[NODE_W-1:0];
                mem_req.rd_en   = !pc_hit && (mem_rd_data.sibling < NO_LINK);
            end
            S_UPD_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = walk_reg;
                mem_req.wr_data = upd_rec;
            end
            S_EXIT_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_reg;
                mem_req.wr_data = exit_rec;
                mem_req.rd_en   = (cur_reg != '0);
                mem_req.rd_addr = rec_reg.parent;
            end
            S_ALLOC: begin
                mem_req.wr_en   = !pool_full;
                mem_req.wr_addr = new_link[NODE_W-1:0];
                mem_req.wr_data = new_rec;
            end
            S_LINK_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = res_rec_reg.parent;
                mem_req.wr_data = link_rec;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            last_used_reg <= '0;
            active_reg    <= 1'b0;
            err_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop valid after a transfer unless a new result is loaded below
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        item_reg <= s_data;
                        if (s_data.opcode == OP_START) begin
                            last_used_reg <= '0;
                            cur_reg       <= '0;
                            active_reg    <= 1'b1;
                            res_rec_reg   <= root_rec;
                            status_reg    <= ST_DONE;
                            idx_reg       <= '0;
                            state_reg     <= S_EMIT;
                        end else begin
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    rec_reg   <= mem_rd_data;
                    delta_reg <= delta;
                    if (item_reg.opcode == OP_READ) begin
                        status_reg  <= ST_READ;
                        idx_reg     <= item_reg.read_index;
                        res_rec_reg <= mem_rd_data;
                        state_reg   <= S_EMIT;
                    end else if (!active_reg || !pid_ok) begin
                        status_reg  <= ST_IGNORED;
                        idx_reg     <= cur_reg;
                        res_rec_reg <= mem_rd_data;
                        state_reg   <= S_EMIT;
                    end else if (item_reg.opcode == OP_EXIT) begin
                        state_reg <= S_EXIT_WR;
                    end else begin
                        head_reg <= mem_rd_data.child;
                        walk_reg <= mem_rd_data.child[NODE_W-1:0];
                        state_reg <= (mem_rd_data.child < NO_LINK) ? S_WALK : S_ALLOC;
                    end
                end
                S_WALK: begin
                    if (pc_hit) begin
                        rec_reg   <= mem_rd_data;
                        state_reg <= S_UPD_WR;
                    end else if (mem_rd_data.sibling >= NO_LINK) begin
                        state_reg <= S_ALLOC;
                    end else begin
                        walk_reg <= mem_rd_data.sibling[NODE_W-1:0];
                    end
                end
                S_UPD_WR: begin
                    cur_reg     <= walk_reg;
                    idx_reg     <= walk_reg;
                    res_rec_reg <= upd_rec;
                    status_reg  <= ST_DONE;
                    state_reg   <= S_EMIT;
                end
                S_EXIT_WR: begin
                    status_reg <= ST_DONE;
                    if (cur_reg == '0) begin
                        // Leaving the root ends the trace
                        active_reg  <= 1'b0;
                        idx_reg     <= '0;
                        res_rec_reg <= exit_rec;
                        state_reg   <= S_EMIT;
                    end else begin
                        cur_reg   <= rec_reg.parent;
                        idx_reg   <= rec_reg.parent;
                        state_reg <= S_RES_WAIT;
                    end
                end
                S_RES_WAIT: begin
                    res_rec_reg <= mem_rd_data;
                    state_reg   <= S_EMIT;
                end
                S_ALLOC: begin
                    if (pool_full) begin
                        active_reg  <= 1'b0;
                        err_reg     <= err_reg + CNT_W'(1);
                        status_reg  <= ST_FULL;
                        idx_reg     <= cur_reg;
                        res_rec_reg <= rec_reg;
                        state_reg   <= S_EMIT;
                    end else begin
                        last_used_reg <= new_link[NODE_W-1:0];
                        cur_reg       <= new_link[NODE_W-1:0];
                        idx_reg       <= new_link[NODE_W-1:0];
                        res_rec_reg   <= new_rec;
                        status_reg    <= ST_DONE;
                        state_reg     <= S_LINK_WR;
                    end
                end
                S_LINK_WR: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.status       <= status_reg;
                        m_data_reg.node_index   <= idx_reg;
                        m_data_reg.first_child  <= res_rec_reg.child;
                        m_data_reg.next_sibling <= res_rec_reg.sibling;
                        m_data_reg.node_pc      <= res_rec_reg.pc;
                        m_data_reg.node_count   <= res_rec_reg.count;
                        m_data_reg.node_time    <= signed'(res_rec_reg.ticks);
                        m_data_reg.error_count  <= err_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- hdl/call_tree_profiler.sv -----
// Top level of the call tree profiler: configuration registers, sequencer, record memory.
`timescale 1ns / 1ps
`default_nettype none

// Call tree profiler. Each transfer on s_ carries one command (enter, exit, read, start)
// and yields exactly one result on m_, in order. All node records live in a single
// 2048-entry memory with one read and one write port and registered read data. Start
// writes the root; read or ignored commands fetch a node; exit writes back the current
// node and, below the root, reads its parent; enter walks the child list, then updates
// the node with the pc or allocates a new node and links it in. One child-list node is
// visited per cycle. The next command is taken once the result is in the output register,
// even if that result has not yet been taken. Reading a node that no start or enter has
// written returns undefined contents. The configuration port is always ready; the user
// must write it only while no command is in flight, which the block does not enforce.
module call_tree_profiler (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire ctp_pkg::in_item_t                    s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output ctp_pkg::out_item_t                        m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ctp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [ctp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ctp_pkg::*;

    cfg_t      cfg_reg;
    mem_req_t  mem_req;
    node_rec_t mem_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_mode  <= TM_USER;
            cfg_reg.filter_pid <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIME_MODE:  cfg_reg.time_mode  <= time_mode_t'(cfg_data[1:0]);
                CFG_FILTER_PID: cfg_reg.filter_pid <= cfg_data[PID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ctp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    ctp_node_ram u_node_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

// ----- hdl/ctp_checker.sv -----
// Port-level checks on the call tree profiler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ctp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire ctp_pkg::out_item_t m_data
);
    import ctp_pkg::*;

    // One command in flight: ready drops right after a transfer
    `CTP_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready stayed high after a transfer")

    // A stalled result holds
    `CTP_ASSERT(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    // Reset leaves no result pending and the input open
    `CTP_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready, "bad state after reset")

endmodule

bind call_tree_profiler ctp_checker u_ctp_checker (.*);

`default_nettype wire
